[rtl/password_door_lock_controller_core_assert.svh]
// assertion macros for the door-lock controller core
// expects clk and arst_n in the scope of each use
`ifndef PASSWORD_DOOR_LOCK_CONTROLLER_CORE_ASSERT_SVH
`define PASSWORD_DOOR_LOCK_CONTROLLER_CORE_ASSERT_SVH

// same-cycle implication
`define PDLC_ASSERT_SAME(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("pdlc: same-cycle check failed");

// next-cycle implication
`define PDLC_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("pdlc: next-cycle check failed");

`endif

[rtl/pdlc_pkg.sv]
// shared constants, types and the timed-stage settle function of the door-lock controller
// no dependencies
package pdlc_pkg;

	localparam int PW_LEN = 5;
	localparam int IDX_W = (PW_LEN > 1) ? $clog2(PW_LEN) : 1;
	localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(PW_LEN - 1);

	localparam logic [3:0] PH_SETUP_PW   = 4'd0;
	localparam logic [3:0] PH_SETUP_CONF = 4'd1;
	localparam logic [3:0] PH_IDLE       = 4'd2;
	localparam logic [3:0] PH_PLUS       = 4'd3;
	localparam logic [3:0] PH_MINUS_OLD  = 4'd4;
	localparam logic [3:0] PH_MINUS_NEW  = 4'd5;
	localparam logic [3:0] PH_MINUS_CONF = 4'd6;
	localparam logic [3:0] PH_OPEN       = 4'd7;
	localparam logic [3:0] PH_HOLD       = 4'd8;
	localparam logic [3:0] PH_CLOSE      = 4'd9;
	localparam logic [3:0] PH_ALARM      = 4'd10;

	localparam logic [1:0] MOTOR_STOP = 2'd0;
	localparam logic [1:0] MOTOR_CW   = 2'd1;
	localparam logic [1:0] MOTOR_ACW  = 2'd2;

	localparam logic [7:0] CMD_PLUS  = 8'h2B;
	localparam logic [7:0] CMD_MINUS = 8'h2D;

	localparam int REG_IDX_W = 3;
	localparam int REG_DATA_W = 16;
	localparam logic [REG_IDX_W-1:0] REG_OPEN_SECONDS  = 3'd0;
	localparam logic [REG_IDX_W-1:0] REG_HOLD_SECONDS  = 3'd1;
	localparam logic [REG_IDX_W-1:0] REG_CLOSE_SECONDS = 3'd2;
	localparam logic [REG_IDX_W-1:0] REG_ALARM_SECONDS = 3'd3;
	localparam logic [REG_IDX_W-1:0] REG_MAX_FAILURES  = 3'd4;

	localparam logic [15:0] RST_OPEN_SECONDS  = 16'd15;
	localparam logic [15:0] RST_HOLD_SECONDS  = 16'd3;
	localparam logic [15:0] RST_CLOSE_SECONDS = 16'd15;
	localparam logic [15:0] RST_ALARM_SECONDS = 16'd60;
	localparam logic [3:0]  RST_MAX_FAILURES  = 4'd3;

	localparam int QD = 4;
	localparam int QA_W = $clog2(QD);
	localparam int QC_W = $clog2(QD + 1);

	typedef struct packed {
		logic [15:0] open_s;
		logic [15:0] hold_s;
		logic [15:0] close_s;
		logic [15:0] alarm_s;
		logic [3:0]  max_fail;
	} cfg_t;

	typedef struct packed {
		logic [3:0]  phase;
		logic [15:0] secs;
		logic [1:0]  motor;
		logic        alarm;
	} ctl_t;

	typedef struct packed {
		logic       reply_valid;
		logic [7:0] reply_byte;
		logic [1:0] motor;
		logic       buzzer;
		logic       busy;
		logic       last;
	} res_t;

	function automatic logic is_busy(logic [3:0] ph);
		return (ph >= PH_OPEN) && (ph <= PH_ALARM);
	endfunction

	// walks through timed stages whose count is already zero
	function automatic ctl_t settle(ctl_t c, cfg_t g);
		ctl_t r;
		r = c;
		for (int k = 0; k < 4; k++) begin
			if (is_busy(r.phase) && (r.secs == 16'd0)) begin
				case (r.phase)
					PH_OPEN: begin
						r.phase = PH_HOLD;
						r.motor = MOTOR_STOP;
						r.secs = g.hold_s;
					end
					PH_HOLD: begin
						r.phase = PH_CLOSE;
						r.motor = MOTOR_ACW;
						r.secs = g.close_s;
					end
					PH_CLOSE: begin
						r.phase = PH_IDLE;
						r.motor = MOTOR_STOP;
					end
					default: begin
						r.phase = PH_IDLE;
						r.alarm = 1'b0;
					end
				endcase
			end
		end
		return r;
	endfunction

endpackage

[rtl/password_door_lock_controller_core.sv]
// Door-lock controller core. Takes one item per clock unless the result queue stalls it: tuser 0
// is a received byte in tdata, tuser 1 is a one-second tick. Each item is registered, processed
// and gives one or two results, which go through a four-entry result queue; input is held off
// only when the queue has fewer than two free entries. Configuration must be written through
// the plain write port only while idle by the user; the block itself does not enforce it.
// Depends on pdlc_pkg, pdlc_cfg, pdlc_fsm, pdlc_out_q and the assertion macro header.
`include "password_door_lock_controller_core_assert.svh"
module password_door_lock_controller_core
	import pdlc_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  s_tvalid,
	output logic                  s_tready,
	input  logic [7:0]            s_tdata,  // rx_byte
	input  logic                  s_tuser,  // action
	output logic                  m_tvalid,
	input  logic                  m_tready,
	output logic [15:0]           m_tdata,  // reply_byte, motor_drive, alarm_sound, busy_res, pad
	output logic                  m_tuser,  // reply_valid
	output logic                  m_tlast,
	input  logic                  wr_en,
	input  logic [REG_IDX_W-1:0]  wr_index,
	input  logic [REG_DATA_W-1:0] wr_data
);

	cfg_t       cfg;
	res_t       res0, res1, head;
	logic       two, room, fire;
	logic       valid_s1, action_s1;
	logic [7:0] byte_s1;

	assign fire = valid_s1 && room;
	assign s_tready = !valid_s1 || room;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			valid_s1 <= 1'b0;
		else if (s_tready)
			valid_s1 <= s_tvalid;
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			action_s1 <= s_tuser;
			byte_s1 <= s_tdata;
		end
	end

	pdlc_cfg u_cfg (
		.clk(clk),
		.arst_n(arst_n),
		.wr_en(wr_en),
		.wr_index(wr_index),
		.wr_data(wr_data),
		.cfg(cfg)
	);

	pdlc_fsm u_fsm (
		.clk(clk),
		.arst_n(arst_n),
		.go(fire),
		.action(action_s1),
		.rx_byte(byte_s1),
		.cfg(cfg),
		.res0(res0),
		.res1(res1),
		.two(two)
	);

	pdlc_out_q u_out_q (
		.clk(clk),
		.arst_n(arst_n),
		.push(fire),
		.two(two),
		.res0(res0),
		.res1(res1),
		.pop(m_tready),
		.room(room),
		.head_valid(m_tvalid),
		.head(head)
	);

	assign m_tdata = {4'd0, head.busy, head.buzzer, head.motor, head.reply_byte};
	assign m_tuser = head.reply_valid;
	assign m_tlast = head.last;

	`PDLC_ASSERT_SAME(a_idle_quiet, m_tvalid && !head.busy, head.motor == MOTOR_STOP && !head.buzzer)
	`PDLC_ASSERT_SAME(a_alarm_no_motor, m_tvalid && head.buzzer, head.motor == MOTOR_STOP)
	`PDLC_ASSERT_NEXT(a_result_queued, fire, m_tvalid)
	`PDLC_ASSERT_NEXT(a_stall_holds, valid_s1 && !room, valid_s1 && $stable(byte_s1))

endmodule

[rtl/pdlc_cfg.sv]
// configuration register file of the door-lock controller
// depends on pdlc_pkg
module pdlc_cfg
	import pdlc_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  wr_en,
	input  logic [REG_IDX_W-1:0]  wr_index,
	input  logic [REG_DATA_W-1:0] wr_data,
	output cfg_t                  cfg
);

	cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.open_s <= RST_OPEN_SECONDS;
			cfg_q.hold_s <= RST_HOLD_SECONDS;
			cfg_q.close_s <= RST_CLOSE_SECONDS;
			cfg_q.alarm_s <= RST_ALARM_SECONDS;
			cfg_q.max_fail <= RST_MAX_FAILURES;
		end else if (wr_en) begin
			case (wr_index)
				REG_OPEN_SECONDS: cfg_q.open_s <= wr_data;
				REG_HOLD_SECONDS: cfg_q.hold_s <= wr_data;
				REG_CLOSE_SECONDS: cfg_q.close_s <= wr_data;
				REG_ALARM_SECONDS: cfg_q.alarm_s <= wr_data;
				REG_MAX_FAILURES: cfg_q.max_fail <= wr_data[3:0];
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

[rtl/pdlc_fsm.sv]
// controller state and single-pass step logic: password entry, compare, door and alarm timing
// depends on pdlc_pkg
module pdlc_fsm
	import pdlc_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       go,
	input  logic       action,
	input  logic [7:0] rx_byte,
	input  cfg_t       cfg,
	output res_t       res0,
	output res_t       res1,
	output logic       two
);

	ctl_t             ctl_q, ctl_d;
	logic [IDX_W-1:0] idx_q, idx_d;
	logic             match_q, match_d;
	logic [3:0]       fail_q, fail_d;
	logic [7:0]       entry_q [PW_LEN];
	logic [7:0]       stored_q [PW_LEN];

	logic       entry_we, copy_en, fail_path;
	logic [1:0] n_rep;
	logic [7:0] rep0, rep1;
	logic [7:0] cmp_byte;
	logic       m;
	logic [3:0] fcnt;
	ctl_t       tmp;

	always_comb begin
		ctl_d = ctl_q;
		idx_d = idx_q;
		match_d = match_q;
		fail_d = fail_q;
		entry_we = 1'b0;
		copy_en = 1'b0;
		fail_path = 1'b0;
		n_rep = 2'd0;
		rep0 = 8'd0;
		rep1 = 8'd0;
		tmp = ctl_q;
		cmp_byte = ((ctl_q.phase == PH_SETUP_CONF) || (ctl_q.phase == PH_MINUS_CONF)) ?
			entry_q[idx_q] : stored_q[idx_q];
		if ((ctl_q.phase == PH_SETUP_PW) || (ctl_q.phase == PH_MINUS_NEW))
			m = match_q;
		else
			m = match_q & (cmp_byte == rx_byte);
		fcnt = fail_q + 4'd1;

		if (!action) begin
			if (!is_busy(ctl_q.phase)) begin
				if (ctl_q.phase == PH_IDLE) begin
					if (rx_byte == CMD_PLUS) begin
						ctl_d.phase = PH_PLUS;
						idx_d = '0;
						match_d = 1'b1;
					end else if (rx_byte == CMD_MINUS) begin
						ctl_d.phase = PH_MINUS_OLD;
						idx_d = '0;
						match_d = 1'b1;
					end
				end else begin
					entry_we = (ctl_q.phase == PH_SETUP_PW) || (ctl_q.phase == PH_MINUS_NEW);
					match_d = m;
					if (idx_q != IDX_LAST) begin
						idx_d = idx_q + 1'b1;
					end else begin
						idx_d = '0;
						match_d = 1'b1;
						case (ctl_q.phase)
							PH_SETUP_PW: ctl_d.phase = PH_SETUP_CONF;
							PH_SETUP_CONF: begin
								n_rep = 2'd1;
								rep0 = {7'd0, m};
								copy_en = m;
								ctl_d.phase = m ? PH_IDLE : PH_SETUP_PW;
							end
							PH_PLUS: begin
								n_rep = 2'd1;
								rep0 = {7'd0, m};
								if (m) begin
									fail_d = 4'd0;
									tmp.phase = PH_OPEN;
									tmp.motor = MOTOR_CW;
									tmp.secs = cfg.open_s;
									ctl_d = settle(tmp, cfg);
								end else begin
									fail_path = 1'b1;
								end
							end
							PH_MINUS_OLD: begin
								n_rep = 2'd1;
								rep0 = {7'd0, m};
								if (m) begin
									fail_d = 4'd0;
									ctl_d.phase = PH_MINUS_NEW;
								end else begin
									fail_path = 1'b1;
								end
							end
							PH_MINUS_NEW: ctl_d.phase = PH_MINUS_CONF;
							default: begin
								n_rep = 2'd1;
								rep0 = {7'd0, m};
								copy_en = m;
								ctl_d.phase = PH_IDLE;
							end
						endcase
						if (fail_path) begin
							n_rep = 2'd2;
							rep1 = {4'd0, fcnt};
							if (fcnt >= cfg.max_fail) begin
								fail_d = 4'd0;
								tmp.phase = PH_ALARM;
								tmp.alarm = 1'b1;
								tmp.secs = cfg.alarm_s;
								ctl_d = settle(tmp, cfg);
							end else begin
								fail_d = fcnt;
								ctl_d.phase = PH_IDLE;
							end
						end
					end
				end
			end
		end else if (is_busy(ctl_q.phase)) begin
			if (ctl_q.secs != 16'd0)
				tmp.secs = ctl_q.secs - 16'd1;
			ctl_d = settle(tmp, cfg);
		end
	end

	always_comb begin
		res0.reply_valid = (n_rep != 2'd0);
		res0.reply_byte = rep0;
		res0.motor = ctl_d.motor;
		res0.buzzer = ctl_d.alarm;
		res0.busy = is_busy(ctl_d.phase);
		res0.last = (n_rep != 2'd2);
		res1.reply_valid = 1'b1;
		res1.reply_byte = rep1;
		res1.motor = ctl_d.motor;
		res1.buzzer = ctl_d.alarm;
		res1.busy = is_busy(ctl_d.phase);
		res1.last = 1'b1;
		two = (n_rep == 2'd2);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_q.phase <= PH_SETUP_PW;
			ctl_q.secs <= 16'd0;
			ctl_q.motor <= MOTOR_STOP;
			ctl_q.alarm <= 1'b0;
			idx_q <= '0;
			match_q <= 1'b1;
			fail_q <= 4'd0;
		end else if (go) begin
			ctl_q <= ctl_d;
			idx_q <= idx_d;
			match_q <= match_d;
			fail_q <= fail_d;
		end
	end

	always_ff @(posedge clk) begin
		if (go && entry_we)
			entry_q[idx_q] <= rx_byte;
		if (go && copy_en)
			stored_q <= entry_q;
	end

endmodule

[rtl/pdlc_out_q.sv]
// result queue of the door-lock controller, takes one or two results per cycle, gives one per pop
// depends on pdlc_pkg
module pdlc_out_q
	import pdlc_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	input  logic two,
	input  res_t res0,
	input  res_t res1,
	input  logic pop,
	output logic room,
	output logic head_valid,
	output res_t head
);

	res_t            buf_q [QD];
	logic [QA_W-1:0] wr_q, rd_q;
	logic [QC_W-1:0] count_q;
	logic            pop_fire;
	logic [QA_W-1:0] wr_next;

	assign head_valid = (count_q != '0);
	assign pop_fire = head_valid && pop;
	assign room = (count_q <= QC_W'(QD - 2));
	assign head = buf_q[rd_q];
	assign wr_next = wr_q + 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q <= '0;
			rd_q <= '0;
			count_q <= '0;
		end else begin
			if (push)
				wr_q <= wr_q + (two ? QA_W'(2) : QA_W'(1));
			if (pop_fire)
				rd_q <= rd_q + 1'b1;
			count_q <= count_q + (push ? (two ? QC_W'(2) : QC_W'(1)) : QC_W'(0))
				- (pop_fire ? QC_W'(1) : QC_W'(0));
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			buf_q[wr_q] <= res0;
			if (two)
				buf_q[wr_next] <= res1;
		end
	end

endmodule
